[hdl/pmi_pkg.sv]
`default_nettype none
package pmi_pkg;

  localparam int MAX_PROJ_WIDTH_DEF  = 4096;
  localparam int MAX_PROJ_HEIGHT_DEF = 1024;

  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 11;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_ADDR_W   = 1;

  localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_WIDTH  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_HEIGHT = 1'd1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 13'd3072;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 11'd768;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 120;

  localparam int DIV_N_W   = 88;
  localparam int DIV_D_W   = 32;
  localparam int DIV_CNT_W = 7;
  localparam int SQ_W      = 64;
  localparam int SQ_CNT_W  = 6;

  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam logic [23:0] SPREAD_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [15:0] best_conf;
    logic [11:0] best_x;
    logic [11:0] best_y;
    logic [15:0] count;
    logic [27:0] sum_x;
    logic [27:0] sum_y;
    logic [39:0] sq_x;
    logic [39:0] sq_y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_ACC_WR,
    DP_MEAN_START,
    DP_MEAN_END,
    DP_MUL_LO,
    DP_MUL_HI,
    DP_VAR_START,
    DP_SQRT_START,
    DP_SPR_START,
    DP_SPR_END,
    DP_PUSH
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_MEAN,
    ST_MEAN_WAIT,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_VAR,
    ST_VAR_WAIT,
    ST_SQRT_WAIT,
    ST_SPR_WAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    dp_op_t op;
    logic   axis;
  } dp_cmd_t;

  typedef struct packed {
    logic req_read;
    logic req_inside;
    logic clr_last;
    logic div_busy;
    logic sqrt_busy;
    logic out_full;
  } dp_status_t;

endpackage
`default_nettype wire

[hdl/pmi_divider.sv]
`default_nettype none
module pmi_divider (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [pmi_pkg::DIV_N_W-1:0] dividend,
  input  wire logic [pmi_pkg::DIV_D_W-1:0] divisor,
  output logic                             busy,
  output logic [pmi_pkg::DIV_N_W-1:0]      quotient
);

  localparam int NW = pmi_pkg::DIV_N_W;
  localparam int DW = pmi_pkg::DIV_D_W;

  logic                          busy_r;
  logic [pmi_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [NW-1:0]                 quo_r;
  logic [DW-1:0]                 rem_r;
  logic [DW-1:0]                 div_r;
  logic [DW:0]                   shifted;
  logic [DW:0]                   rem_nxt;
  logic                          ge;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    ge      = shifted >= {1'b0, div_r};
    rem_nxt = ge ? (shifted - {1'b0, div_r}) : shifted;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= pmi_pkg::DIV_CNT_W'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == pmi_pkg::DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= rem_nxt[DW-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

[hdl/pmi_isqrt.sv]
`default_nettype none
module pmi_isqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [pmi_pkg::SQ_W-1:0] value,
  output logic                          busy,
  output logic [31:0]                   root
);

  localparam int W = pmi_pkg::SQ_W;

  logic                         busy_r;
  logic [pmi_pkg::SQ_CNT_W-1:0] cnt_r;
  logic [W-1:0]                 v_r;
  logic [W-1:0]                 root_r;
  logic [W-1:0]                 bit_r;
  logic [W-1:0]                 trial;
  logic                         ge;

  always_comb begin
    trial = root_r + bit_r;
    ge    = v_r >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= pmi_pkg::SQ_CNT_W'(W / 2);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == pmi_pkg::SQ_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= value;
      root_r <= '0;
      bit_r  <= {2'b01, {(W-2){1'b0}}};
    end else if (busy_r) begin
      if (ge) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign busy = busy_r;
  assign root = root_r[31:0];

endmodule
`default_nettype wire

[hdl/pmi_datapath.sv]
`default_nettype none
module pmi_datapath #(
  parameter int MAX_PROJ_WIDTH  = pmi_pkg::MAX_PROJ_WIDTH_DEF,
  parameter int MAX_PROJ_HEIGHT = pmi_pkg::MAX_PROJ_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire pmi_pkg::dp_cmd_t               cmd,
  output pmi_pkg::dp_status_t                 status,
  input  wire logic                           in_tvalid,
  input  wire logic [pmi_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [pmi_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pmi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pmi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_PROJ_WIDTH * MAX_PROJ_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [13:0] MAXW_V = 14'(MAX_PROJ_WIDTH);
  localparam logic [12:0] MAXH_V = 13'(MAX_PROJ_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [pmi_pkg::ENTRY_W-1:0] mem [DEPTH];

  logic [pmi_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [pmi_pkg::HEIGHT_REG_W-1:0] height_r;
  logic [ADDR_W-1:0]                clr_cnt_r;
  logic [ADDR_W-1:0]                addr_r;
  logic                             inside_r;
  logic [11:0]                      cx_r;
  logic [11:0]                      cy_r;
  logic [15:0]                      conf_r;
  pmi_pkg::entry_t                  ent_r;
  logic [35:0]                      plo_r;
  logic [55:0]                      bsq_r;
  logic [55:0]                      a_r;
  logic [31:0]                      nn_r;
  logic [11:0]                      mean_x_r;
  logic [11:0]                      mean_y_r;
  logic [23:0]                      spread_x_r;
  logic [23:0]                      spread_y_r;
  logic                             out_valid_r;
  logic [pmi_pkg::OUT_DATA_W-1:0]   out_data_r;

  logic [11:0]  in_cx;
  logic [11:0]  in_cy;
  logic [15:0]  in_px;
  logic [15:0]  in_py;
  logic [15:0]  in_conf;
  logic [13:0]  act_w;
  logic [12:0]  act_h;
  logic         in_inside;
  logic [31:0]  idx_full;
  logic [ADDR_W-1:0] rd_addr;

  pmi_pkg::entry_t acc_ent;
  logic [15:0] n;
  logic [27:0] sel_sum;
  logic [39:0] sel_sq;
  logic [55:0] d_val;
  logic [12:0] w_div;

  logic                        div_start;
  logic [pmi_pkg::DIV_N_W-1:0] div_num;
  logic [pmi_pkg::DIV_D_W-1:0] div_den;
  logic                        div_busy;
  logic [pmi_pkg::DIV_N_W-1:0] div_q;
  logic                        sq_start;
  logic                        sq_busy;
  logic [31:0]                 sigma;
  logic [23:0]                 spread_val;
  logic [11:0]                 mean_val;

  assign in_cx   = in_tdata[11:0];
  assign in_cy   = in_tdata[23:12];
  assign in_px   = in_tdata[39:24];
  assign in_py   = in_tdata[55:40];
  assign in_conf = in_tdata[71:56];

  always_comb begin
    act_w     = ({1'b0, width_r} < MAXW_V) ? {1'b0, width_r} : MAXW_V;
    act_h     = ({2'b0, height_r} < MAXH_V) ? {2'b0, height_r} : MAXH_V;
    in_inside = (in_px < {2'b0, act_w}) && (in_py < {3'b0, act_h});
    idx_full  = 32'(in_py) * 32'(MAX_PROJ_WIDTH) + 32'(in_px);
    rd_addr   = idx_full[ADDR_W-1:0];
  end

  always_comb begin
    n       = ent_r.count;
    sel_sum = cmd.axis ? ent_r.sum_y : ent_r.sum_x;
    sel_sq  = cmd.axis ? ent_r.sq_y : ent_r.sq_x;
    d_val   = (a_r > bsq_r) ? (a_r - bsq_r) : '0;
    w_div   = (width_r == '0) ? 13'd1 : width_r;
    mean_val   = (n == '0) ? '0 : div_q[11:0];
    spread_val = (n == '0) ? '0 :
                 ((|div_q[pmi_pkg::DIV_N_W-1:24]) ? pmi_pkg::SPREAD_MAX : div_q[23:0]);
  end

  always_comb begin
    acc_ent = ent_r;
    if (conf_r > ent_r.best_conf) begin
      acc_ent.best_conf = conf_r;
      acc_ent.best_x    = cx_r;
      acc_ent.best_y    = cy_r;
    end
    if (ent_r.count != pmi_pkg::COUNT_MAX) begin
      acc_ent.count = ent_r.count + 16'd1;
      acc_ent.sum_x = ent_r.sum_x + 28'(cx_r);
      acc_ent.sum_y = ent_r.sum_y + 28'(cy_r);
      acc_ent.sq_x  = ent_r.sq_x + 40'(24'(cx_r) * 24'(cx_r));
      acc_ent.sq_y  = ent_r.sq_y + 40'(24'(cy_r) * 24'(cy_r));
    end
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd.op)
      pmi_pkg::DP_MEAN_START: begin
        div_start = 1'b1;
        div_num   = pmi_pkg::DIV_N_W'(29'(sel_sum) + 29'(n[15:1]));
        div_den   = 32'(n);
      end
      pmi_pkg::DP_VAR_START: begin
        div_start = 1'b1;
        div_num   = {d_val, 32'b0};
        div_den   = nn_r;
      end
      pmi_pkg::DP_SPR_START: begin
        div_start = 1'b1;
        div_num   = pmi_pkg::DIV_N_W'(sigma);
        div_den   = 32'(w_div);
      end
      default: begin
      end
    endcase
  end

  assign sq_start = (cmd.op == pmi_pkg::DP_SQRT_START);

  pmi_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .busy     (div_busy),
    .quotient (div_q)
  );

  pmi_isqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (div_q[pmi_pkg::SQ_W-1:0]),
    .busy  (sq_busy),
    .root  (sigma)
  );

  // store: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.op == pmi_pkg::DP_CLEAR) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.op == pmi_pkg::DP_ACC_WR) begin
      mem[addr_r] <= acc_ent;
    end
    if (cmd.op == pmi_pkg::DP_LOAD) begin
      ent_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= pmi_pkg::WIDTH_RESET;
      height_r    <= pmi_pkg::HEIGHT_RESET;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          pmi_pkg::CFG_PROJ_WIDTH:  width_r  <= cfg_wdata;
          pmi_pkg::CFG_PROJ_HEIGHT: height_r <= cfg_wdata[pmi_pkg::HEIGHT_REG_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == pmi_pkg::DP_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.op == pmi_pkg::DP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pmi_pkg::DP_LOAD: begin
        addr_r   <= rd_addr;
        inside_r <= in_inside;
        cx_r     <= in_cx;
        cy_r     <= in_cy;
        conf_r   <= in_conf;
      end
      pmi_pkg::DP_MEAN_END: begin
        if (cmd.axis) mean_y_r <= mean_val;
        else          mean_x_r <= mean_val;
      end
      pmi_pkg::DP_MUL_LO: begin
        plo_r <= 36'(n) * 36'(sel_sq[19:0]);
        bsq_r <= 56'(sel_sum) * 56'(sel_sum);
        nn_r  <= 32'(n) * 32'(n);
      end
      pmi_pkg::DP_MUL_HI: begin
        a_r <= {36'(n) * 36'(sel_sq[39:20]), 20'b0} + 56'(plo_r);
      end
      pmi_pkg::DP_SPR_END: begin
        if (cmd.axis) spread_y_r <= spread_val;
        else          spread_x_r <= spread_val;
      end
      pmi_pkg::DP_PUSH: begin
        if (inside_r) begin
          out_data_r <= {ent_r.count[7:0], spread_y_r, spread_x_r, mean_y_r, mean_x_r,
                         ent_r.best_conf, ent_r.best_y, ent_r.best_x};
        end else begin
          out_data_r <= '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status.req_read   = in_tuser;
    status.req_inside = in_inside & in_tvalid;
    status.clr_last   = (clr_cnt_r == LAST_ADDR);
    status.div_busy   = div_busy;
    status.sqrt_busy  = sq_busy;
    status.out_full   = out_valid_r;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

[hdl/pmi_ctrl.sv]
`default_nettype none
module pmi_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire pmi_pkg::dp_status_t status,
  output pmi_pkg::dp_cmd_t         cmd
);

  pmi_pkg::state_t state_r, state_nxt;
  logic            axis_r, axis_nxt;
  logic            accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pmi_pkg::ST_CLEAR;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  assign in_tready = (state_r == pmi_pkg::ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd.op    = pmi_pkg::DP_NOP;
    cmd.axis  = axis_r;
    unique case (state_r)
      pmi_pkg::ST_CLEAR: begin
        cmd.op = pmi_pkg::DP_CLEAR;
        if (status.clr_last) state_nxt = pmi_pkg::ST_IDLE;
      end
      pmi_pkg::ST_IDLE: begin
        axis_nxt = 1'b0;
        if (accept) begin
          cmd.op = pmi_pkg::DP_LOAD;
          if (status.req_read) begin
            state_nxt = status.req_inside ? pmi_pkg::ST_MEAN : pmi_pkg::ST_PUSH;
          end else if (status.req_inside) begin
            state_nxt = pmi_pkg::ST_ACC;
          end
        end
      end
      pmi_pkg::ST_ACC: begin
        cmd.op    = pmi_pkg::DP_ACC_WR;
        state_nxt = pmi_pkg::ST_IDLE;
      end
      pmi_pkg::ST_MEAN: begin
        cmd.op    = pmi_pkg::DP_MEAN_START;
        state_nxt = pmi_pkg::ST_MEAN_WAIT;
      end
      pmi_pkg::ST_MEAN_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = pmi_pkg::DP_MEAN_END;
          state_nxt = pmi_pkg::ST_MUL_LO;
        end
      end
      pmi_pkg::ST_MUL_LO: begin
        cmd.op    = pmi_pkg::DP_MUL_LO;
        state_nxt = pmi_pkg::ST_MUL_HI;
      end
      pmi_pkg::ST_MUL_HI: begin
        cmd.op    = pmi_pkg::DP_MUL_HI;
        state_nxt = pmi_pkg::ST_VAR;
      end
      pmi_pkg::ST_VAR: begin
        cmd.op    = pmi_pkg::DP_VAR_START;
        state_nxt = pmi_pkg::ST_VAR_WAIT;
      end
      pmi_pkg::ST_VAR_WAIT: begin
        if (!status.div_busy) begin
          cmd.op    = pmi_pkg::DP_SQRT_START;
          state_nxt = pmi_pkg::ST_SQRT_WAIT;
        end
      end
      pmi_pkg::ST_SQRT_WAIT: begin
        if (!status.sqrt_busy) begin
          cmd.op    = pmi_pkg::DP_SPR_START;
          state_nxt = pmi_pkg::ST_SPR_WAIT;
        end
      end
      pmi_pkg::ST_SPR_WAIT: begin
        if (!status.div_busy) begin
          cmd.op = pmi_pkg::DP_SPR_END;
          if (axis_r) begin
            state_nxt = pmi_pkg::ST_PUSH;
          end else begin
            axis_nxt  = 1'b1;
            state_nxt = pmi_pkg::ST_MEAN;
          end
        end
      end
      pmi_pkg::ST_PUSH: begin
        if (!status.out_full) begin
          cmd.op    = pmi_pkg::DP_PUSH;
          state_nxt = pmi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pmi_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/projector_map_inverter_unit.sv]
`default_nettype none
// Inverse correspondence map. An accumulate request is one read and one write of the
// single-port per-pixel store. A readout request for a pixel inside the bounds runs the
// mean, variance and spread divisions on the shared bit-serial divider and the square
// root unit, for x and then y; one outside the bounds is answered with zeros. The result
// then sits in the output register while the next request is taken. After reset the
// store is cleared one entry a cycle, all MAX_PROJ_WIDTH * MAX_PROJ_HEIGHT entries
// (4194304 by default), during which no request is taken; configuration writes are.
module projector_map_inverter_unit #(
  parameter int MAX_PROJ_WIDTH  = pmi_pkg::MAX_PROJ_WIDTH_DEF,
  parameter int MAX_PROJ_HEIGHT = pmi_pkg::MAX_PROJ_HEIGHT_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // cam_x, cam_y, proj_x, proj_y, confidence
  input  wire logic [pmi_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // best_cam_x, best_cam_y, best_confidence, mean_x, mean_y, spread_x, spread_y,
  // hit_count
  output logic [pmi_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pmi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pmi_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  pmi_pkg::dp_cmd_t    cmd;
  pmi_pkg::dp_status_t status;

  pmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pmi_datapath #(
    .MAX_PROJ_WIDTH  (MAX_PROJ_WIDTH),
    .MAX_PROJ_HEIGHT (MAX_PROJ_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

endmodule
`default_nettype wire

[bench/pmi_checker.sv]
module pmi_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [pmi_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [pmi_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [pmi_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [pmi_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  fails,
  output int                                  pending
);
  import pmi_pkg::*;

  localparam int MAXW = MAX_PROJ_WIDTH_DEF;
  localparam int MAXH = MAX_PROJ_HEIGHT_DEF;

  typedef struct packed {
    logic [7:0]  hits;
    logic [23:0] spr_y;
    logic [23:0] spr_x;
    logic [11:0] avg_y;
    logic [11:0] avg_x;
    logic [15:0] conf;
    logic [11:0] by;
    logic [11:0] bx;
  } readout_t;

  logic [12:0] pw;
  logic [10:0] ph;
  entry_t      pixel_map [int unsigned];
  readout_t    readout_q [$];

  assign pending = readout_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic [23:0] spread_calc(longint unsigned s, longint unsigned sq,
                                              longint unsigned n);
    longint unsigned a, b, d, nn, vi, r, v, w, q;
    if (n == 0) return '0;
    a  = n * sq;
    b  = s * s;
    d  = a > b ? a - b : 0;
    nn = n * n;
    vi = d / nn;
    r  = d % nn;
    v  = (vi << 32) + ((r << 32) / nn);
    w  = pw == 0 ? 1 : pw;
    q  = int_sqrt(v) / w;
    return q > 64'hFFFFFF ? 24'hFFFFFF : q[23:0];
  endfunction

  function automatic logic [11:0] mean_calc(longint unsigned s, longint unsigned n);
    longint unsigned m;
    if (n == 0) return '0;
    m = (s + n / 2) / n;
    return m[11:0];
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    fails++;
  endtask

  task automatic map_request(logic op, logic [IN_DATA_W-1:0] d);
    logic [11:0] cx, cy;
    logic [15:0] px, py, cf;
    int unsigned aw, ah, k;
    logic        hit;
    entry_t      e;
    readout_t    rd;
    cx = d[11:0];
    cy = d[23:12];
    px = d[39:24];
    py = d[55:40];
    cf = d[71:56];
    aw = pw < MAXW ? pw : MAXW;
    ah = ph < MAXH ? ph : MAXH;
    hit = px < aw && py < ah;
    k = py * MAXW + px;
    e = '0;
    if (hit && pixel_map.exists(k)) e = pixel_map[k];
    if (op == 1'b0) begin
      if (!hit) return;
      if (cf > e.best_conf) begin
        e.best_conf = cf;
        e.best_x = cx;
        e.best_y = cy;
      end
      if (e.count < COUNT_MAX) begin
        e.count++;
        e.sum_x += cx;
        e.sum_y += cy;
        e.sq_x += 40'(cx) * 40'(cx);
        e.sq_y += 40'(cy) * 40'(cy);
      end
      pixel_map[k] = e;
    end else begin
      rd = '0;
      if (hit) begin
        rd.bx    = e.best_x;
        rd.by    = e.best_y;
        rd.conf  = e.best_conf;
        rd.avg_x = mean_calc(e.sum_x, e.count);
        rd.avg_y = mean_calc(e.sum_y, e.count);
        rd.spr_x = spread_calc(e.sum_x, e.sq_x, e.count);
        rd.spr_y = spread_calc(e.sum_y, e.sq_y, e.count);
        rd.hits  = e.count[7:0];
      end
      readout_q = {readout_q, rd};
    end
  endtask

  always @(posedge clk) begin
    readout_t got, want;
    if (!rst_n) begin
      pw <= WIDTH_RESET;
      ph <= HEIGHT_RESET;
      fails = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_PROJ_WIDTH) pw <= cfg_wdata[12:0];
        else if (cfg_addr == CFG_PROJ_HEIGHT) ph <= cfg_wdata[10:0];
      end
      if (in_tvalid && in_tready) map_request(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (readout_q.size() == 0) begin
          report("unexpected result", out_tdata[63:0], 0);
        end else begin
          want = readout_q.pop_front();
          if (got.bx != want.bx) report("best_cam_x", got.bx, want.bx);
          if (got.by != want.by) report("best_cam_y", got.by, want.by);
          if (got.conf != want.conf) report("best_confidence", got.conf, want.conf);
          if (got.avg_x != want.avg_x) report("mean_x", got.avg_x, want.avg_x);
          if (got.avg_y != want.avg_y) report("mean_y", got.avg_y, want.avg_y);
          if (got.spr_x != want.spr_x) report("spread_x", got.spr_x, want.spr_x);
          if (got.spr_y != want.spr_y) report("spread_y", got.spr_y, want.spr_y);
          if (got.hits != want.hits) report("hit_count", got.hits, want.hits);
        end
      end
    end
  end
endmodule

[bench/projector_map_inverter_unit_tb.sv]
module projector_map_inverter_unit_tb;
  import pmi_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    fails;
  int                    pending;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  int unsigned cur_w, cur_h;
  int unsigned pool_x [8];
  int unsigned pool_y [8];
  int          stall_left;

  projector_map_inverter_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  pmi_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= gap_len();
    end else begin
      out_tready <= 1'b1;
      stall_left <= $urandom_range(0, 20);
    end
  end

  task automatic send(logic op, logic [11:0] cx, logic [11:0] cy, logic [15:0] px,
                      logic [15:0] py, logic [15:0] cf);
    int g;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {cf, py, px, cy, cx};
    do @(posedge clk); while (!in_tready);
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (700) @(posedge clk);
  endtask

  task automatic set_size(logic [12:0] w, logic [12:0] h);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PROJ_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr  <= CFG_PROJ_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w = w < MAX_PROJ_WIDTH_DEF ? w : MAX_PROJ_WIDTH_DEF;
    cur_h = h[10:0] < MAX_PROJ_HEIGHT_DEF ? h[10:0] : MAX_PROJ_HEIGHT_DEF;
  endtask

  task automatic random_phase(int n);
    int r, p;
    for (int i = 0; i < 8; i++) begin
      pool_x[i] = cur_w == 0 ? 0 : $urandom_range(0, cur_w - 1);
      pool_y[i] = cur_h == 0 ? 0 : $urandom_range(0, cur_h - 1);
    end
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      if (r < 70)
        send(OP_ACC, 12'($urandom), 12'($urandom), 16'(pool_x[p]), 16'(pool_y[p]),
             16'($urandom));
      else if (r < 80)
        send(1'($urandom), 12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom));
      else
        send(OP_READ, 12'($urandom), 12'($urandom), 16'(pool_x[p]), 16'(pool_y[p]),
             16'($urandom));
    end
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    cur_w      = 3072;
    cur_h      = 768;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty pixel, zero confidence, tie, extremes, outside readout
    send(OP_READ, 0, 0, 5, 5, 0);
    send(OP_ACC, 100, 200, 5, 5, 0);
    send(OP_READ, 0, 0, 5, 5, 0);
    send(OP_ACC, 4095, 4095, 5, 5, 16'hFFFF);
    send(OP_ACC, 1, 2, 5, 5, 16'hFFFF);
    send(OP_ACC, 0, 0, 5, 5, 16'h1000);
    send(OP_READ, 0, 0, 5, 5, 0);
    send(OP_ACC, 4095, 0, 3071, 767, 16'h0001);
    send(OP_ACC, 0, 4095, 3071, 767, 16'h0002);
    send(OP_READ, 0, 0, 3071, 767, 0);
    send(OP_ACC, 7, 7, 3072, 0, 16'h8000);
    send(OP_ACC, 7, 7, 0, 768, 16'h8000);
    send(OP_READ, 0, 0, 3072, 0, 0);
    send(OP_READ, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(OP_ACC, 12'hAAA, 12'h555, 0, 0, 16'h5555);
    send(OP_ACC, 12'h555, 12'hAAA, 0, 0, 16'hAAAA);
    send(OP_READ, 12'hFFF, 12'hFFF, 0, 0, 16'hFFFF);
    drain();
    random_phase(260);

    set_size(1, 1);
    send(OP_ACC, 4095, 0, 0, 0, 16'h0010);
    send(OP_ACC, 0, 4095, 0, 0, 16'h0010);
    send(OP_READ, 0, 0, 0, 0, 0);
    send(OP_READ, 0, 0, 1, 0, 0);
    random_phase(200);

    set_size(4096, 1024);
    send(OP_ACC, 4095, 4095, 4095, 1023, 16'hFFFF);
    send(OP_READ, 0, 0, 4095, 1023, 0);
    random_phase(230);

    // above the parameters: bounds clamp, spread divided by the full register
    set_size(13'h1FFF, 13'h1FFF);
    send(OP_ACC, 4095, 0, 4095, 1023, 16'h0100);
    send(OP_ACC, 0, 4095, 4095, 1023, 16'h0100);
    send(OP_READ, 0, 0, 4095, 1023, 0);
    send(OP_READ, 0, 0, 4096, 1024, 0);
    random_phase(230);

    set_size(0, 0);
    send(OP_ACC, 9, 9, 0, 0, 16'hFFFF);
    send(OP_READ, 0, 0, 0, 0, 0);
    random_phase(120);

    set_size(13'($urandom_range(1, 64)), {2'b0, 11'($urandom_range(1, 32))});
    random_phase(260);

    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
